// ===== src/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// implication checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== src/bdl_pkg.sv =====
// shared constants, codes and types of the button debouncer
package bdl_pkg;

   localparam int NUM_BUTTONS = 5;
   localparam int PIN_COUNT   = 5;
   localparam int BTN_ID_W    = 3;
   localparam int COUNT_W     = 8;
   localparam int TIME_W      = 32;
   localparam int EVENT_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic CMD_POLL = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_PRESS  = 2'd1;
   localparam logic [EVENT_W-1:0] EV_LONG   = 2'd2;
   localparam logic [EVENT_W-1:0] EV_REPEAT = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_POLLS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_MS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_MS       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_FIRE_MASK = 2'd3;

   localparam logic [COUNT_W-1:0]   RST_DEBOUNCE_POLLS  = 8'd2;
   localparam logic [TIME_W-1:0]    RST_LONG_PRESS_MS   = 32'd2000;
   localparam logic [TIME_W-1:0]    RST_REPEAT_MS       = 32'd200;
   localparam logic [PIN_COUNT-1:0] RST_PRESS_FIRE_MASK = 5'd30;

   typedef struct packed {
      logic [COUNT_W-1:0] debounce_polls;
      logic [TIME_W-1:0]  long_press_ms;
      logic [TIME_W-1:0]  repeat_ms;
   } cfg_type;

   typedef struct packed {
      logic              step;
      logic              poll;
      logic              pop;
      logic              raw;
      logic              fire_on_press;
      logic [TIME_W-1:0] now;
   } button_cmd_type;

   typedef struct packed {
      logic [EVENT_W-1:0] slot;
      logic [EVENT_W-1:0] spare;
   } queue_type;

   function automatic queue_type post_event(queue_type q, logic en, logic [EVENT_W-1:0] ev);
      queue_type r;
      r = q;
      if (en) begin
         if (q.slot == EV_NONE) begin
            r.slot = ev;
         end else if (q.spare == EV_NONE) begin
            r.spare = ev;
         end
      end
      return r;
   endfunction

endpackage

// ===== src/bdl_button.sv =====
// one button: debounce, long press and repeat timing, two-entry event queue
module bdl_button import bdl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  button_cmd_type     cmd,
   output logic               pressed_next,
   output logic [EVENT_W-1:0] pop_event
);

   logic               level_ff, level_in;
   logic               last_raw_ff, last_raw_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  press_time_ff, press_time_in;
   logic [TIME_W-1:0]  repeat_time_ff, repeat_time_in;
   logic               long_done_ff, long_done_in;
   queue_type          queue_ff, queue_in;

   logic               accept, press_edge, release_edge, long_fire, repeat_fire;
   logic               long_done_1, long_done_2;
   logic [TIME_W-1:0]  press_time_1, repeat_time_1, repeat_time_2;
   logic [TIME_W-1:0]  hold_time, since_repeat;
   queue_type          q1, q2, q3;

   always_comb begin
      if (cmd.raw == last_raw_ff) begin
         count_in = (count_ff < cfg.debounce_polls) ? count_ff + 1'b1 : count_ff;
      end else begin
         count_in = '0;
      end
      last_raw_in  = cmd.raw;
      accept       = count_in >= cfg.debounce_polls;
      level_in     = accept ? cmd.raw : level_ff;
      press_edge   = accept && level_ff && !cmd.raw;
      release_edge = accept && !level_ff && cmd.raw;

      press_time_1  = press_edge ? cmd.now : press_time_ff;
      repeat_time_1 = press_edge ? cmd.now : repeat_time_ff;
      long_done_1   = press_edge ? 1'b0 : long_done_ff;
      q1 = post_event(queue_ff,
                      (press_edge && cmd.fire_on_press) ||
                      (release_edge && !cmd.fire_on_press && !long_done_ff),
                      EV_PRESS);

      hold_time     = cmd.now - press_time_1;
      long_fire     = !level_in && !long_done_1 && (hold_time >= cfg.long_press_ms);
      long_done_2   = long_done_1 || long_fire;
      repeat_time_2 = long_fire ? cmd.now : repeat_time_1;
      q2 = post_event(q1, long_fire, EV_LONG);

      since_repeat  = cmd.now - repeat_time_2;
      repeat_fire   = !level_in && long_done_2 && (since_repeat >= cfg.repeat_ms);
      q3 = post_event(q2, repeat_fire, EV_REPEAT);

      press_time_in  = press_time_1;
      repeat_time_in = repeat_fire ? cmd.now : repeat_time_2;
      long_done_in   = long_done_2;
      queue_in       = q3;
   end

   assign pressed_next = (cmd.poll ? level_in : level_ff) == 1'b0;
   assign pop_event    = cmd.pop ? queue_ff.slot : EV_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= 1'b1;
         last_raw_ff    <= 1'b1;
         count_ff       <= '0;
         press_time_ff  <= '0;
         repeat_time_ff <= '0;
         long_done_ff   <= 1'b0;
         queue_ff       <= '{slot: EV_NONE, spare: EV_NONE};
      end else if (cmd.step && cmd.poll) begin
         level_ff       <= level_in;
         last_raw_ff    <= last_raw_in;
         count_ff       <= count_in;
         press_time_ff  <= press_time_in;
         repeat_time_ff <= repeat_time_in;
         long_done_ff   <= long_done_in;
         queue_ff       <= queue_in;
      end else if (cmd.step && cmd.pop) begin
         queue_ff       <= '{slot: queue_ff.spare, spare: EV_NONE};
      end
   end

endmodule

// ===== src/button_debounce_long_press_repeat.sv =====
// top level: input register, per-button units, result register, control registers
//
// Debouncer with long press and auto-repeat for five active-low keys.
// Request channel (req_*): cmd 0 polls all keys with raw_levels and now_ms,
// cmd 1 pops one queued event of button_id. Every request gives exactly one
// response word (rsp_*): the popped event (zero on a poll or an unknown id),
// the accepted pressed mask and whether any key is pressed.
// A request word is held in an input register; from there it updates the
// per-button state and loads the response register, which drives rsp_valid.
// One word per cycle is sustained while rsp_ready stays high; all per-button
// logic works in parallel.
// If the receiver stalls, the response register holds its word and the input
// register takes one more word; req_ready then follows rsp_ready.
// Control registers are written through csr_wen, csr_index and csr_wdata;
// the user must write them only while the block is idle, the block itself does not enforce this.
// Synchronous reset empties both registers, releases every key, clears all
// event queues and restores the control registers to their reset values.
module button_debounce_long_press_repeat import bdl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [PIN_COUNT-1:0]   req_raw_levels,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic [BTN_ID_W-1:0]    req_button_id,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [EVENT_W-1:0]     rsp_event_res,
   output logic                   rsp_any_pressed,
   output logic [PIN_COUNT-1:0]   rsp_pressed_mask,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                  in_valid_ff;
   logic                  in_cmd_ff;
   logic [PIN_COUNT-1:0]  in_levels_ff;
   logic [TIME_W-1:0]     in_now_ff;
   logic [BTN_ID_W-1:0]   in_id_ff;

   logic                  out_valid_ff;
   logic [EVENT_W-1:0]    out_event_ff, out_event_in;
   logic                  out_any_ff, out_any_in;
   logic [PIN_COUNT-1:0]  out_mask_ff, out_mask_in;

   cfg_type               cfg_ff;
   logic [PIN_COUNT-1:0]  fire_mask_ff;

   logic                  advance;
   logic [NUM_BUTTONS-1:0] pressed;
   logic [EVENT_W-1:0]    pop_ev [NUM_BUTTONS];

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
      button_cmd_type bcmd;
      logic           pin_raw;
      logic           pin_fire;
      if (b < PIN_COUNT) begin : g_pin
         assign pin_raw  = in_levels_ff[b];
         assign pin_fire = fire_mask_ff[b];
      end else begin : g_nopin
         assign pin_raw  = 1'b1;
         assign pin_fire = 1'b0;
      end
      always_comb begin
         bcmd.step          = advance;
         bcmd.poll          = in_cmd_ff == CMD_POLL;
         bcmd.pop           = (in_cmd_ff == CMD_POP) && (in_id_ff == BTN_ID_W'(b));
         bcmd.raw           = pin_raw;
         bcmd.fire_on_press = pin_fire;
         bcmd.now           = in_now_ff;
      end
      bdl_button u_button (
         .clock        (clock),
         .reset        (reset),
         .cfg          (cfg_ff),
         .cmd          (bcmd),
         .pressed_next (pressed[b]),
         .pop_event    (pop_ev[b])
      );
   end

   always_comb begin
      out_event_in = EV_NONE;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         out_event_in = out_event_in | pop_ev[b];
      end
      out_any_in = |pressed;
      for (int b = 0; b < PIN_COUNT; b++) begin
         out_mask_in[b] = (b < NUM_BUTTONS) ? pressed[b] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff    <= req_cmd;
         in_levels_ff <= req_raw_levels;
         in_now_ff    <= req_now_ms;
         in_id_ff     <= req_button_id;
      end
      if (advance) begin
         out_event_ff <= out_event_in;
         out_any_ff   <= out_any_in;
         out_mask_ff  <= out_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_polls <= RST_DEBOUNCE_POLLS;
         cfg_ff.long_press_ms  <= RST_LONG_PRESS_MS;
         cfg_ff.repeat_ms      <= RST_REPEAT_MS;
         fire_mask_ff          <= RST_PRESS_FIRE_MASK;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_DEBOUNCE_POLLS:  cfg_ff.debounce_polls <= csr_wdata[COUNT_W-1:0];
            CSR_LONG_PRESS_MS:   cfg_ff.long_press_ms  <= csr_wdata[TIME_W-1:0];
            CSR_REPEAT_MS:       cfg_ff.repeat_ms      <= csr_wdata[TIME_W-1:0];
            CSR_PRESS_FIRE_MASK: fire_mask_ff          <= csr_wdata[PIN_COUNT-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = out_event_ff;
   assign rsp_any_pressed  = out_any_ff;
   assign rsp_pressed_mask = out_mask_ff;

endmodule

// ===== src/bdl_checker.sv =====
// port-level checks of the button debouncer and their binding
`include "assert_macros.svh"

module bdl_checker import bdl_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [EVENT_W-1:0]   rsp_event_res,
   input logic                 rsp_any_pressed,
   input logic [PIN_COUNT-1:0] rsp_pressed_mask
);

   logic                           req_fire;
   logic                           rsp_stall;
   logic [EVENT_W+PIN_COUNT:0]     rsp_word;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_event_res, rsp_any_pressed, rsp_pressed_mask};

   // a stalled response word stays put
   `ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_word)))

   // no response right after reset
   `ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // any_pressed agrees with the mask
   `ASSERT_IMPL(a_any_mask, clock, reset, rsp_valid |-> (rsp_any_pressed == (|rsp_pressed_mask)))

   // with both registers full, request ready follows response ready
   `ASSERT_IMPL(a_full_ready, clock, reset, (req_fire && rsp_stall) |=> (req_ready == rsp_ready))

endmodule

bind button_debounce_long_press_repeat bdl_checker u_bdl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_event_res    (rsp_event_res),
   .rsp_any_pressed  (rsp_any_pressed),
   .rsp_pressed_mask (rsp_pressed_mask)
);

// ===== dv/tb_top.sv =====
// testbench for the button debouncer: scripted key traffic checked against a predictor
module tb_top import bdl_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [EVENT_W-1:0]   event_res;
      logic                 any_pressed;
      logic [PIN_COUNT-1:0] pressed_mask;
   } key_resp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_cmd = CMD_POLL;
   logic [PIN_COUNT-1:0]   req_raw_levels = '1;
   logic [TIME_W-1:0]      req_now_ms = '0;
   logic [BTN_ID_W-1:0]    req_button_id = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [EVENT_W-1:0]     rsp_event_res;
   logic                   rsp_any_pressed;
   logic [PIN_COUNT-1:0]   rsp_pressed_mask;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEBOUNCE_POLLS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int error_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int req_idle_pct = 36;
   int rsp_stall_pct = 36;

   key_resp_type pending_responses [$];

   // predictor copy of the control registers and per-key state
   logic [COUNT_W-1:0]   cfg_debounce;
   logic [TIME_W-1:0]    cfg_long_ms;
   logic [TIME_W-1:0]    cfg_repeat_ms;
   logic [PIN_COUNT-1:0] cfg_fire_mask;

   logic               key_level [NUM_BUTTONS];
   logic               key_last_raw [NUM_BUTTONS];
   logic [COUNT_W-1:0] key_stable [NUM_BUTTONS];
   logic [TIME_W-1:0]  key_press_at [NUM_BUTTONS];
   logic [TIME_W-1:0]  key_repeat_at [NUM_BUTTONS];
   logic               key_long_fired [NUM_BUTTONS];
   logic [EVENT_W-1:0] key_ev_head [NUM_BUTTONS];
   logic [EVENT_W-1:0] key_ev_tail [NUM_BUTTONS];

   button_debounce_long_press_repeat i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_raw_levels   (req_raw_levels),
      .req_now_ms       (req_now_ms),
      .req_button_id    (req_button_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_any_pressed  (rsp_any_pressed),
      .rsp_pressed_mask (rsp_pressed_mask),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void reset_key_state();
      cfg_debounce  = RST_DEBOUNCE_POLLS;
      cfg_long_ms   = RST_LONG_PRESS_MS;
      cfg_repeat_ms = RST_REPEAT_MS;
      cfg_fire_mask = RST_PRESS_FIRE_MASK;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         key_level[b]      = 1'b1;
         key_last_raw[b]   = 1'b1;
         key_stable[b]     = '0;
         key_press_at[b]   = '0;
         key_repeat_at[b]  = '0;
         key_long_fired[b] = 1'b0;
         key_ev_head[b]    = EV_NONE;
         key_ev_tail[b]    = EV_NONE;
      end
   endfunction

   // two-slot queue, new events dropped when full
   function automatic void queue_key_event(int b, logic [EVENT_W-1:0] ev);
      if (key_ev_head[b] == EV_NONE) begin
         key_ev_head[b] = ev;
      end else if (key_ev_tail[b] == EV_NONE) begin
         key_ev_tail[b] = ev;
      end
   endfunction

   function automatic key_resp_type next_key_response(logic cmd, logic [PIN_COUNT-1:0] levels,
         logic [TIME_W-1:0] now, logic [BTN_ID_W-1:0] id);
      key_resp_type      r;
      logic              raw;
      logic              fire;
      logic              prev;
      logic [TIME_W-1:0] held;
      r = '0;
      r.event_res = EV_NONE;
      if (cmd == CMD_POLL) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            raw  = (b < PIN_COUNT) ? levels[b] : 1'b1;
            fire = (b < PIN_COUNT) ? cfg_fire_mask[b] : 1'b0;
            if (raw == key_last_raw[b]) begin
               if (key_stable[b] < cfg_debounce) begin
                  key_stable[b] = key_stable[b] + 1'b1;
               end
            end else begin
               key_stable[b] = '0;
               key_last_raw[b] = raw;
            end
            if (key_stable[b] >= cfg_debounce) begin
               prev = key_level[b];
               key_level[b] = raw;
               if (prev && !raw) begin
                  key_press_at[b] = now;
                  key_repeat_at[b] = now;
                  key_long_fired[b] = 1'b0;
                  if (fire) begin
                     queue_key_event(b, EV_PRESS);
                  end
               end else if (!prev && raw) begin
                  if (!fire && !key_long_fired[b]) begin
                     queue_key_event(b, EV_PRESS);
                  end
               end
            end
            if (!key_level[b]) begin
               held = now - key_press_at[b];
               if (!key_long_fired[b] && held >= cfg_long_ms) begin
                  key_long_fired[b] = 1'b1;
                  queue_key_event(b, EV_LONG);
                  key_repeat_at[b] = now;
               end
               held = now - key_repeat_at[b];
               if (key_long_fired[b] && held >= cfg_repeat_ms) begin
                  key_repeat_at[b] = now;
                  queue_key_event(b, EV_REPEAT);
               end
            end
         end
      end else if (id < NUM_BUTTONS) begin
         r.event_res = key_ev_head[id];
         key_ev_head[id] = key_ev_tail[id];
         key_ev_tail[id] = EV_NONE;
      end
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (!key_level[b]) begin
            r.any_pressed = 1'b1;
            if (b < PIN_COUNT) begin
               r.pressed_mask[b] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
      $display("mismatch on %s: expected %0h, got %0h at %0t ns", what, exp_val, got_val, $time);
      error_count++;
   endtask

   // response side: random stalls and in-order compare
   always @(posedge clock) begin : rsp_check
      key_resp_type exp_w;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response word", 32'h0,
               32'({rsp_event_res, rsp_any_pressed, rsp_pressed_mask}));
         end else begin
            exp_w = pending_responses.pop_front();
            words_checked++;
            if (rsp_event_res !== exp_w.event_res) begin
               report_mismatch("event_res", 32'(exp_w.event_res), 32'(rsp_event_res));
            end
            if (rsp_any_pressed !== exp_w.any_pressed) begin
               report_mismatch("any_pressed", 32'(exp_w.any_pressed), 32'(rsp_any_pressed));
            end
            if (rsp_pressed_mask !== exp_w.pressed_mask) begin
               report_mismatch("pressed_mask", 32'(exp_w.pressed_mask), 32'(rsp_pressed_mask));
            end
         end
      end
   end

   task automatic send_word(logic cmd, logic [PIN_COUNT-1:0] levels, logic [TIME_W-1:0] now,
         logic [BTN_ID_W-1:0] id);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_raw_levels <= levels;
      req_now_ms     <= now;
      req_button_id  <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_responses.push_back(next_key_response(cmd, levels, now, id));
      words_sent++;
   endtask

   task automatic poll_keys(logic [PIN_COUNT-1:0] levels, logic [TIME_W-1:0] now);
      send_word(CMD_POLL, levels, now, BTN_ID_W'($urandom_range(7)));
   endtask

   task automatic pop_key(logic [BTN_ID_W-1:0] id);
      send_word(CMD_POP, PIN_COUNT'($urandom), $urandom, id);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(logic [COUNT_W-1:0] deb, logic [TIME_W-1:0] long_ms,
         logic [TIME_W-1:0] rep_ms, logic [PIN_COUNT-1:0] fire_mask);
      wait_idle();
      write_reg(CSR_DEBOUNCE_POLLS, CSR_DATA_W'(deb));
      write_reg(CSR_LONG_PRESS_MS, long_ms);
      write_reg(CSR_REPEAT_MS, rep_ms);
      write_reg(CSR_PRESS_FIRE_MASK, CSR_DATA_W'(fire_mask));
      csr_wen <= 1'b0;
      cfg_debounce  = deb;
      cfg_long_ms   = long_ms;
      cfg_repeat_ms = rep_ms;
      cfg_fire_mask = fire_mask;
   endtask

   // key scripts: hold a pattern for a number of polls, with pops and bounce mixed in
   task automatic run_traffic(int n_items, int min_hold, int max_hold, int unsigned max_step,
         logic [TIME_W-1:0] start_ms, int noise_pct);
      int                   sent;
      int                   hold;
      logic [PIN_COUNT-1:0] target;
      logic [PIN_COUNT-1:0] levels;
      logic [TIME_W-1:0]    t_ms;
      sent = 0;
      t_ms = start_ms;
      target = '1;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0: begin
               target = PIN_COUNT'($urandom);
            end
            1, 2: begin
               target = '1;
            end
            default: begin
               target = target ^ (PIN_COUNT'(1) << $urandom_range(PIN_COUNT - 1));
            end
         endcase
         hold = $urandom_range(max_hold, min_hold);
         for (int i = 0; i < hold && sent < n_items; i++) begin
            if ($urandom_range(2) == 0) begin
               if ($urandom_range(99) < 85) begin
                  pop_key(BTN_ID_W'($urandom_range(NUM_BUTTONS - 1)));
               end else begin
                  pop_key(BTN_ID_W'($urandom_range(7, NUM_BUTTONS)));
               end
               sent++;
            end
            t_ms = t_ms + $urandom_range(max_step);
            levels = target;
            if ($urandom_range(99) < noise_pct) begin
               levels = target ^ (PIN_COUNT'(1) << $urandom_range(PIN_COUNT - 1));
            end
            poll_keys(levels, t_ms);
            sent++;
         end
      end
   endtask

   // after reset: every id popped, nothing queued, unknown ids give none
   task automatic test_empty_pops();
      for (int id = 0; id < 8; id++) begin
         pop_key(BTN_ID_W'(id));
      end
   endtask

   // zero debounce and zero hold times: press, long press and repeat on one poll
   task automatic test_instant_accept();
      configure(8'd0, 32'd0, 32'd0, 5'h1F);
      poll_keys(5'h00, 32'hFFFF_FFFF);
      pop_key(BTN_ID_W'(0));
      pop_key(BTN_ID_W'(4));
      pop_key(BTN_ID_W'(4));
      pop_key(BTN_ID_W'(4));
      poll_keys(5'h1F, 32'h0000_0000);
      pop_key(BTN_ID_W'(0));
   endtask

   // longest hold time reached only across the wrap, then press on release
   task automatic test_wrapped_long_press();
      configure(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h00);
      poll_keys(5'h1E, 32'd1);
      poll_keys(5'h1E, 32'd2);
      poll_keys(5'h1E, 32'd1);
      poll_keys(5'h1F, 32'd5);
      poll_keys(5'h1F, 32'd6);
      pop_key(BTN_ID_W'(0));
      pop_key(BTN_ID_W'(0));
      poll_keys(5'h0F, 32'd7);
      poll_keys(5'h0F, 32'd8);
      poll_keys(5'h1F, 32'd9);
      poll_keys(5'h1F, 32'd10);
      pop_key(BTN_ID_W'(4));
   endtask

   task automatic test_default_traffic();
      configure(RST_DEBOUNCE_POLLS, RST_LONG_PRESS_MS, RST_REPEAT_MS, RST_PRESS_FIRE_MASK);
      run_traffic(140, 1, 8, 400, 32'd0, 8);
   endtask

   task automatic test_no_debounce_traffic();
      configure(8'd0, 32'd0, 32'd1, 5'h00);
      run_traffic(120, 1, 4, 50, $urandom, 10);
   endtask

   task automatic test_wrap_traffic();
      configure(8'd1, 32'd50, 32'd10, 5'h1F);
      run_traffic(120, 1, 6, 30, 32'hFFFF_FE00, 8);
   endtask

   task automatic test_slow_debounce();
      configure(8'd255, 32'd300, 32'd0, 5'b10101);
      run_traffic(400, 256, 262, 5, $urandom, 0);
   endtask

   task automatic test_extreme_times();
      configure(8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PIN_COUNT'($urandom));
      run_traffic(100, 1, 8, 32'hFFFF_FFFF, $urandom, 8);
   endtask

   task automatic test_back_to_back();
      configure(8'd2, 32'd100, 32'd20, PIN_COUNT'($urandom));
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      run_traffic(200, 1, 10, 40, $urandom, 5);
      req_idle_pct = 36;
      rsp_stall_pct = 36;
   endtask

   initial begin
      reset_key_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_pops();
      test_instant_accept();
      test_wrapped_long_press();
      test_default_traffic();
      test_no_debounce_traffic();
      test_wrap_traffic();
      test_slow_debounce();
      test_extreme_times();
      test_back_to_back();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("%0d words sent, %0d responses checked, %0d mismatches",
         words_sent, words_checked, error_count);
      $display("covered empty and unknown pops, debounce 0 to 255, hold and repeat extremes, wrap");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/bdl_pkg.sv
src/bdl_button.sv
src/button_debounce_long_press_repeat.sv
src/bdl_checker.sv
dv/tb_top.sv
